@@ src/ebrt_pkg.sv @@
// Shared types, constants and codes of the engine busy ratio tracker.
`timescale 1ns / 1ps
`default_nettype none
package ebrt_pkg;

  localparam int CounterSlots  = 64;
  localparam int GroupSlots    = 64;
  localparam int RatioFracBits = 16;
  localparam int SlotAw        = $clog2(CounterSlots);
  localparam int GroupAw       = $clog2(GroupSlots);
  localparam int GroupCw       = $clog2(GroupSlots + 1);
  localparam int DivCw         = $clog2(RatioFracBits);

  localparam logic [1:0] STATUS_AVAIL   = 2'd0;
  localparam logic [1:0] STATUS_UNAVAIL = 2'd1;
  localparam logic [1:0] STATUS_UNSUPP  = 2'd2;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLOSE  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] ctr_ident;
    logic [63:0] eng_ident;
    logic [63:0] busy_count;
    logic [63:0] total_count;
    logic        total_present;
    logic [31:0] engine_capacity;
    logic [62:0] timestamp_ns;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [RatioFracBits:0]   busy_ratio;
  } out_word_t;

  typedef struct packed {
    logic [63:0] identity;
    logic [63:0] busy;
    logic [63:0] total;
  } slot_word_t;

  typedef struct packed {
    logic [63:0] identity;
    logic [63:0] busy_sum;
    logic [63:0] total_max;
    logic [31:0] capacity;
    logic        total_valid;
  } group_word_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CHECK, OP_SRD, OP_SCMP, OP_MISS, OP_MONO1, OP_MONO2,
    OP_GRD, OP_GCMP, OP_GNEW, OP_GUPD1, OP_GUPD2, OP_GUPD3, OP_GWB, OP_WSLOT,
    OP_CTIME, OP_CDEC, OP_CEND, OP_GLD, OP_MULHI, OP_MULSUM, OP_DIVCHK,
    OP_DIV, OP_BEST, OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_SRD, ST_SCMP, ST_MISS, ST_MONO1, ST_MONO2,
    ST_GRD, ST_GCMP, ST_GNEW, ST_GUPD1, ST_GUPD2, ST_GUPD3, ST_GWB, ST_WSLOT,
    ST_CTIME, ST_CDEC, ST_CGRD, ST_CGLD, ST_MULHI, ST_MULSUM, ST_DIVCHK,
    ST_DIV, ST_BEST, ST_OUT
  } state_e;

  typedef struct packed {
    op_e  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_close;
    logic invalid;
    logic hit;
    logic last_slot;
    logic mono;
    logic grp_end;
    logic grp_match;
    logic grp_full;
    logic grp_tv;
    logic den_ok;
    logic div_ge;
    logic div_last;
    logic direct_out;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

@@ src/ebrt_in_if.sv @@
// Input channel of the tracker: valid/ready and one sample or close word.
`timescale 1ns / 1ps
`default_nettype none
interface ebrt_in_if;
  logic              valid;
  logic              ready;
  ebrt_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/ebrt_out_if.sv @@
// Output channel of the tracker: valid/ready and one result word.
`timescale 1ns / 1ps
`default_nettype none
interface ebrt_out_if;
  logic               valid;
  logic               ready;
  ebrt_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/engine_busy_ratio_tracker.sv @@
// Top level of the engine busy ratio tracker.
//
// Channels: in_i takes one word per accepted valid/ready edge, either a
// counter sample (req_type 0) or the close of an observation (req_type 1).
// out_o gives one word per close: status and busy_ratio in Q1.16.
// Samples give no output word.
// A sample scans the 64-entry counter table slot by slot (read, then
// compare); on a hit whose counts did not move backward it scans the group
// table (up to 64 groups) and updates the matching or a new group. An
// invalid sample ends after the check, a miss after the full slot scan.
// A close goes through each group in turn (multiply in two halves on one
// 32x32 multiplier, then a 16-step restoring divide); the multiply is
// skipped for a group with a total delta, the divide for a zero denominator.
// Throughput: one word at a time; in_i.ready is high only when idle, i.e.
// in the cycle after the previous word is done.
// Reset clears slot valid, seen and total-valid bits, group count, flags
// and the previous close time; table memories need no clearing pass.
// A stalled receiver holds the result in the output register; the next
// sample is still taken, and a further close waits until that word leaves.
`timescale 1ns / 1ps
`default_nettype none
module engine_busy_ratio_tracker (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ebrt_in_if.sink    in_i,
  ebrt_out_if.source out_o
);

  ebrt_pkg::cmd_t  cmd;
  ebrt_pkg::stat_t stat;

  // sequencing
  ebrt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // tables, arithmetic and output register
  ebrt_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

@@ src/ebrt_ctrl.sv @@
// Sequencing state machine of the tracker.
`timescale 1ns / 1ps
`default_nettype none
module ebrt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ebrt_pkg::stat_t stat_i,
  output ebrt_pkg::cmd_t     cmd_o
);

  ebrt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ebrt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o.op        = ebrt_pkg::OP_NONE;
    cmd_o.in_ready  = 1'b0;
    case (state_q)
      ebrt_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.op = ebrt_pkg::OP_LOAD;
          state_d  = stat_i.in_close ? ebrt_pkg::ST_CTIME : ebrt_pkg::ST_CHECK;
        end
      end
      ebrt_pkg::ST_CHECK: begin
        cmd_o.op = ebrt_pkg::OP_CHECK;
        state_d  = stat_i.invalid ? ebrt_pkg::ST_IDLE : ebrt_pkg::ST_SRD;
      end
      ebrt_pkg::ST_SRD: begin
        cmd_o.op = ebrt_pkg::OP_SRD;
        state_d  = ebrt_pkg::ST_SCMP;
      end
      ebrt_pkg::ST_SCMP: begin
        cmd_o.op = ebrt_pkg::OP_SCMP;
        if (stat_i.hit)            state_d = ebrt_pkg::ST_MONO1;
        else if (stat_i.last_slot) state_d = ebrt_pkg::ST_MISS;
        else                       state_d = ebrt_pkg::ST_SRD;
      end
      ebrt_pkg::ST_MISS: begin
        cmd_o.op = ebrt_pkg::OP_MISS;
        state_d  = ebrt_pkg::ST_IDLE;
      end
      ebrt_pkg::ST_MONO1: begin
        cmd_o.op = ebrt_pkg::OP_MONO1;
        state_d  = ebrt_pkg::ST_MONO2;
      end
      ebrt_pkg::ST_MONO2: begin
        cmd_o.op = ebrt_pkg::OP_MONO2;
        state_d  = stat_i.mono ? ebrt_pkg::ST_GRD : ebrt_pkg::ST_WSLOT;
      end
      ebrt_pkg::ST_GRD: begin
        if (stat_i.grp_end) begin
          state_d = ebrt_pkg::ST_GNEW;
        end else begin
          cmd_o.op = ebrt_pkg::OP_GRD;
          state_d  = ebrt_pkg::ST_GCMP;
        end
      end
      ebrt_pkg::ST_GCMP: begin
        cmd_o.op = ebrt_pkg::OP_GCMP;
        state_d  = stat_i.grp_match ? ebrt_pkg::ST_GUPD1 : ebrt_pkg::ST_GRD;
      end
      ebrt_pkg::ST_GNEW: begin
        cmd_o.op = ebrt_pkg::OP_GNEW;
        state_d  = stat_i.grp_full ? ebrt_pkg::ST_WSLOT : ebrt_pkg::ST_GUPD1;
      end
      ebrt_pkg::ST_GUPD1: begin
        cmd_o.op = ebrt_pkg::OP_GUPD1;
        state_d  = ebrt_pkg::ST_GUPD2;
      end
      ebrt_pkg::ST_GUPD2: begin
        cmd_o.op = ebrt_pkg::OP_GUPD2;
        state_d  = ebrt_pkg::ST_GUPD3;
      end
      ebrt_pkg::ST_GUPD3: begin
        cmd_o.op = ebrt_pkg::OP_GUPD3;
        state_d  = ebrt_pkg::ST_GWB;
      end
      ebrt_pkg::ST_GWB: begin
        cmd_o.op = ebrt_pkg::OP_GWB;
        state_d  = ebrt_pkg::ST_WSLOT;
      end
      ebrt_pkg::ST_WSLOT: begin
        cmd_o.op = ebrt_pkg::OP_WSLOT;
        state_d  = ebrt_pkg::ST_IDLE;
      end
      ebrt_pkg::ST_CTIME: begin
        cmd_o.op = ebrt_pkg::OP_CTIME;
        state_d  = ebrt_pkg::ST_CDEC;
      end
      ebrt_pkg::ST_CDEC: begin
        cmd_o.op = ebrt_pkg::OP_CDEC;
        state_d  = stat_i.direct_out ? ebrt_pkg::ST_OUT : ebrt_pkg::ST_CGRD;
      end
      ebrt_pkg::ST_CGRD: begin
        if (stat_i.grp_end) begin
          cmd_o.op = ebrt_pkg::OP_CEND;
          state_d  = ebrt_pkg::ST_OUT;
        end else begin
          cmd_o.op = ebrt_pkg::OP_GRD;
          state_d  = ebrt_pkg::ST_CGLD;
        end
      end
      ebrt_pkg::ST_CGLD: begin
        cmd_o.op = ebrt_pkg::OP_GLD;
        state_d  = stat_i.grp_tv ? ebrt_pkg::ST_DIVCHK : ebrt_pkg::ST_MULHI;
      end
      ebrt_pkg::ST_MULHI: begin
        cmd_o.op = ebrt_pkg::OP_MULHI;
        state_d  = ebrt_pkg::ST_MULSUM;
      end
      ebrt_pkg::ST_MULSUM: begin
        cmd_o.op = ebrt_pkg::OP_MULSUM;
        state_d  = ebrt_pkg::ST_DIVCHK;
      end
      ebrt_pkg::ST_DIVCHK: begin
        cmd_o.op = ebrt_pkg::OP_DIVCHK;
        if (!stat_i.den_ok)     state_d = ebrt_pkg::ST_CGRD;
        else if (stat_i.div_ge) state_d = ebrt_pkg::ST_BEST;
        else                    state_d = ebrt_pkg::ST_DIV;
      end
      ebrt_pkg::ST_DIV: begin
        cmd_o.op = ebrt_pkg::OP_DIV;
        if (stat_i.div_last) state_d = ebrt_pkg::ST_BEST;
      end
      ebrt_pkg::ST_BEST: begin
        cmd_o.op = ebrt_pkg::OP_BEST;
        state_d  = ebrt_pkg::ST_CGRD;
      end
      ebrt_pkg::ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.op = ebrt_pkg::OP_OUT;
          state_d  = ebrt_pkg::ST_IDLE;
        end
      end
      default: state_d = ebrt_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ src/ebrt_datapath.sv @@
// Tables, arithmetic and result register of the tracker.
`timescale 1ns / 1ps
`default_nettype none
module ebrt_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ebrt_pkg::cmd_t cmd_i,
  output ebrt_pkg::stat_t     stat_o,
  ebrt_in_if.sink             in_i,
  ebrt_out_if.source          out_o
);

  localparam int SA = ebrt_pkg::SlotAw;
  localparam int GA = ebrt_pkg::GroupAw;
  localparam int GC = ebrt_pkg::GroupCw;
  localparam int DC = ebrt_pkg::DivCw;
  localparam int FB = ebrt_pkg::RatioFracBits;

  // memories
  ebrt_pkg::slot_word_t  slot_mem [ebrt_pkg::CounterSlots];
  ebrt_pkg::group_word_t grp_mem  [ebrt_pkg::GroupSlots];

  ebrt_pkg::in_word_t    req_q;
  ebrt_pkg::slot_word_t  srd_q;
  ebrt_pkg::group_word_t grd_q, grp_q;
  ebrt_pkg::out_word_t   out_q;
  logic                  out_valid_q;

  logic [ebrt_pkg::CounterSlots-1:0] slot_valid_q, slot_seen_q, slot_tv_q;
  logic [SA-1:0]  idx_q, s_q, free_idx_q;
  logic           free_found_q, mono_busy_q, tdok_q, sum_ok_q;
  logic [GC-1:0]  gidx_q, gused_q;
  logic [GA-1:0]  g_q;
  logic [63:0]    d_q, td_q, den_q, r_q;
  logic           den_ok_q, ovf_q, cmp_q, any_q, ltv_q, has_q;
  logic [62:0]    lts_q, el_q, phi_q;
  logic [63:0]    plo_q;
  logic [DC-1:0]  cnt_q;
  logic [FB:0]    q_q, best_q;
  logic [1:0]     st_q;

  // shared 32x32 multiplier
  logic [31:0] mul_a;
  logic [63:0] prod;
  assign mul_a = (cmd_i.op == ebrt_pkg::OP_MULHI) ? {1'b0, el_q[62:32]} : el_q[31:0];
  assign prod  = mul_a * grd_q.capacity;

  logic [64:0] sum65;
  logic [32:0] mid33;
  logic [64:0] rr;
  logic        rr_ge;
  logic        out_free;
  logic        slot_wr, grp_wr;
  logic [SA-1:0] slot_wa;
  ebrt_pkg::slot_word_t slot_wd;

  assign sum65 = {1'b0, grp_q.busy_sum} + {1'b0, d_q};
  assign mid33 = {1'b0, phi_q[31:0]} + {1'b0, plo_q[63:32]};
  assign rr    = {r_q, 1'b0};
  assign rr_ge = rr >= {1'b0, den_q};
  assign out_free = !out_valid_q || out_o.ready;

  assign slot_wr = (cmd_i.op == ebrt_pkg::OP_WSLOT) ||
                   ((cmd_i.op == ebrt_pkg::OP_MISS) && free_found_q);
  assign slot_wa = (cmd_i.op == ebrt_pkg::OP_MISS) ? free_idx_q : s_q;
  assign slot_wd = '{identity: req_q.ctr_ident, busy: req_q.busy_count,
                     total: req_q.total_present ? req_q.total_count : 64'd0};
  assign grp_wr  = cmd_i.op == ebrt_pkg::OP_GWB;

  always_ff @(posedge clk_i) begin
    if (slot_wr) slot_mem[slot_wa] <= slot_wd;
    if (cmd_i.op == ebrt_pkg::OP_SRD) srd_q <= slot_mem[idx_q];
    if (grp_wr) grp_mem[g_q] <= grp_q;
    if (cmd_i.op == ebrt_pkg::OP_GRD) grd_q <= grp_mem[gidx_q[GA-1:0]];
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ebrt_pkg::OP_LOAD: req_q <= in_i.data;
      ebrt_pkg::OP_CHECK: idx_q <= '0;
      ebrt_pkg::OP_SCMP: begin
        if (slot_valid_q[idx_q] && srd_q.identity == req_q.ctr_ident) s_q <= idx_q;
        else if (!slot_valid_q[idx_q] && !free_found_q) free_idx_q <= idx_q;
        idx_q <= idx_q + 1'b1;
      end
      ebrt_pkg::OP_MISS: s_q <= free_idx_q;
      ebrt_pkg::OP_MONO1: mono_busy_q <= req_q.busy_count >= srd_q.busy;
      ebrt_pkg::OP_MONO2: tdok_q <= req_q.total_present && slot_tv_q[s_q];
      ebrt_pkg::OP_GCMP: begin
        grp_q <= grd_q;
        g_q   <= gidx_q[GA-1:0];
      end
      ebrt_pkg::OP_GNEW: begin
        grp_q <= '{identity: req_q.eng_ident, busy_sum: 64'd0, total_max: 64'd0,
                   capacity: 32'd1, total_valid: 1'b0};
        g_q   <= gused_q[GA-1:0];
      end
      ebrt_pkg::OP_GUPD1: begin
        d_q  <= req_q.busy_count - srd_q.busy;
        td_q <= req_q.total_count - srd_q.total;
      end
      ebrt_pkg::OP_GUPD2: begin
        sum_ok_q <= !sum65[64];
        if (!sum65[64]) grp_q.busy_sum <= sum65[63:0];
      end
      ebrt_pkg::OP_GUPD3: begin
        if (sum_ok_q) begin
          if (req_q.engine_capacity > grp_q.capacity) grp_q.capacity <= req_q.engine_capacity;
          if (tdok_q) begin
            grp_q.total_valid <= 1'b1;
            if (td_q > grp_q.total_max) grp_q.total_max <= td_q;
          end
        end
      end
      ebrt_pkg::OP_CTIME: begin
        el_q <= (ltv_q && req_q.timestamp_ns > lts_q) ? req_q.timestamp_ns - lts_q : '0;
      end
      ebrt_pkg::OP_CDEC: begin
        best_q <= '0;
        if (ovf_q)                        st_q <= ebrt_pkg::STATUS_UNAVAIL;
        else if (!cmp_q || el_q == '0)
          st_q <= any_q ? ebrt_pkg::STATUS_UNAVAIL : ebrt_pkg::STATUS_UNSUPP;
      end
      ebrt_pkg::OP_CEND:
        st_q <= has_q ? ebrt_pkg::STATUS_AVAIL : ebrt_pkg::STATUS_UNAVAIL;
      ebrt_pkg::OP_GLD: begin
        if (grd_q.total_valid) begin
          den_q    <= grd_q.total_max;
          den_ok_q <= grd_q.total_max != 64'd0;
        end else begin
          plo_q <= prod;
        end
      end
      ebrt_pkg::OP_MULHI: phi_q <= prod[62:0];
      ebrt_pkg::OP_MULSUM: begin
        den_q    <= {mid33[31:0], plo_q[31:0]};
        den_ok_q <= !mid33[32] && (phi_q[62:32] == '0);
      end
      ebrt_pkg::OP_DIVCHK: begin
        r_q   <= grd_q.busy_sum;
        cnt_q <= '0;
        q_q   <= (grd_q.busy_sum >= den_q) ? (FB+1)'(1) << FB : '0;
      end
      ebrt_pkg::OP_DIV: begin
        r_q   <= rr_ge ? 64'(rr - {1'b0, den_q}) : rr[63:0];
        q_q   <= {q_q[FB-1:0], rr_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      ebrt_pkg::OP_BEST: if (q_q > best_q) best_q <= q_q;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      slot_seen_q  <= '0;
      slot_tv_q    <= '0;
      free_found_q <= 1'b0;
      gidx_q       <= '0;
      gused_q      <= '0;
      ovf_q        <= 1'b0;
      cmp_q        <= 1'b0;
      any_q        <= 1'b0;
      ltv_q        <= 1'b0;
      lts_q        <= '0;
      has_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      // a new word may replace one leaving in the same cycle
      if (cmd_i.op == ebrt_pkg::OP_OUT) out_valid_q <= 1'b1;
      else if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      if (slot_wr) begin
        slot_valid_q[slot_wa] <= 1'b1;
        slot_seen_q[slot_wa]  <= 1'b1;
        slot_tv_q[slot_wa]    <= req_q.total_present;
      end
      case (cmd_i.op)
        ebrt_pkg::OP_CHECK: begin
          any_q        <= 1'b1;
          free_found_q <= 1'b0;
          if (stat_o.invalid) ovf_q <= 1'b1;
        end
        ebrt_pkg::OP_SCMP:
          if (!slot_valid_q[idx_q] && !free_found_q) free_found_q <= 1'b1;
        ebrt_pkg::OP_MISS: if (!free_found_q) ovf_q <= 1'b1;
        ebrt_pkg::OP_MONO2: gidx_q <= '0;
        ebrt_pkg::OP_GCMP: if (!stat_o.grp_match) gidx_q <= gidx_q + 1'b1;
        ebrt_pkg::OP_GNEW: begin
          if (stat_o.grp_full) ovf_q <= 1'b1;
          else gused_q <= gused_q + 1'b1;
        end
        ebrt_pkg::OP_GUPD2: if (sum65[64]) ovf_q <= 1'b1;
        ebrt_pkg::OP_GUPD3: if (sum_ok_q) cmp_q <= 1'b1;
        ebrt_pkg::OP_CTIME: begin
          lts_q        <= req_q.timestamp_ns;
          ltv_q        <= 1'b1;
          slot_valid_q <= slot_valid_q & slot_seen_q;
          slot_seen_q  <= '0;
        end
        ebrt_pkg::OP_CDEC: begin
          gidx_q <= '0;
          has_q  <= 1'b0;
        end
        ebrt_pkg::OP_DIVCHK: if (!den_ok_q) gidx_q <= gidx_q + 1'b1;
        ebrt_pkg::OP_BEST: begin
          has_q  <= 1'b1;
          gidx_q <= gidx_q + 1'b1;
        end
        ebrt_pkg::OP_OUT: begin
          out_q.status     <= st_q;
          out_q.busy_ratio <= (st_q == ebrt_pkg::STATUS_AVAIL) ? best_q : '0;
          gused_q          <= '0;
          ovf_q            <= 1'b0;
          cmp_q            <= 1'b0;
          any_q            <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign in_i.ready  = cmd_i.in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    stat_o.in_valid   = in_i.valid;
    stat_o.in_close   = in_i.data.req_type == ebrt_pkg::REQ_CLOSE;
    stat_o.invalid    = (req_q.ctr_ident == 64'd0) ||
                        (req_q.eng_ident == 64'd0) ||
                        (req_q.engine_capacity == 32'd0);
    stat_o.hit        = slot_valid_q[idx_q] && (srd_q.identity == req_q.ctr_ident);
    stat_o.last_slot  = idx_q == SA'(ebrt_pkg::CounterSlots - 1);
    stat_o.mono       = mono_busy_q && (!req_q.total_present || !slot_tv_q[s_q] ||
                        req_q.total_count >= srd_q.total);
    stat_o.grp_end    = gidx_q == gused_q;
    stat_o.grp_match  = grd_q.identity == req_q.eng_ident;
    stat_o.grp_full   = gused_q >= GC'(ebrt_pkg::GroupSlots);
    stat_o.grp_tv     = grd_q.total_valid;
    stat_o.den_ok     = den_ok_q;
    stat_o.div_ge     = grd_q.busy_sum >= den_q;
    stat_o.div_last   = cnt_q == DC'(FB - 1);
    stat_o.direct_out = ovf_q || !cmp_q || (el_q == '0);
    stat_o.out_free   = out_free;
  end

endmodule
`default_nettype wire
